[sv/gwf_pkg.sv]
// Shared types and codes for the grid wall follower step core.
// Used by gwf_grid, gwf_ctrl and grid_wall_follower_step_core; no dependencies.
package gwf_pkg;

    localparam int GWF_GRID_SIZE = 16;
    localparam int GWF_DIM       = 16;                 // store is 16 x 16, positions are 4 bits
    localparam int GWF_CELLS     = GWF_DIM * GWF_DIM;
    localparam int GWF_AW        = $clog2(GWF_CELLS);

    // commands
    localparam logic [1:0] CMD_LOAD    = 2'd0;
    localparam logic [1:0] CMD_STEP    = 2'd1;
    localparam logic [1:0] CMD_RESTART = 2'd2;

    // cell contents
    localparam logic [1:0] CELL_OPEN = 2'd0;
    localparam logic [1:0] CELL_WALL = 2'd1;
    localparam logic [1:0] CELL_MARK = 2'd2;
    localparam logic [1:0] CELL_NONE = 2'd3;           // undefined kind, stored as open

    // headings
    localparam logic [1:0] DIR_N = 2'd0;
    localparam logic [1:0] DIR_E = 2'd1;
    localparam logic [1:0] DIR_S = 2'd2;
    localparam logic [1:0] DIR_W = 2'd3;

    // configuration register indexes
    localparam logic [1:0] REG_START_X   = 2'd0;
    localparam logic [1:0] REG_START_Y   = 2'd1;
    localparam logic [1:0] REG_START_DIR = 2'd2;

    // reset values of robot state and start registers
    localparam logic [3:0] RST_X   = 4'd0;
    localparam logic [3:0] RST_Y   = 4'd1;
    localparam logic [1:0] RST_DIR = DIR_E;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SELF_RD,
        ST_SELF_EVAL,
        ST_NB,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic              we;
        logic [GWF_AW-1:0] waddr;
        logic [1:0]        wdata;
        logic [GWF_AW-1:0] raddr;
    } t_mem_req;

endpackage

[sv/gwf_grid.sv]
// Grid cell store: 256 x 2-bit synchronous memory, one write and one read port,
// registered read data. Per-entry valid bits make unwritten cells read as open. Uses gwf_pkg.
module gwf_grid (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  gwf_pkg::t_mem_req i_mem,
    output logic [1:0]        o_rdata
);
    import gwf_pkg::*;

    logic [1:0]           r_mem [GWF_CELLS];
    logic [GWF_CELLS-1:0] r_valid;
    logic [1:0]           r_rd;
    logic                 r_rdv;

    always_ff @(posedge i_clk) begin
        if (i_mem.we) begin
            r_mem[i_mem.waddr] <= i_mem.wdata;
        end
        r_rd <= r_mem[i_mem.raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_rdv   <= 1'b0;
        end else begin
            if (i_mem.we) begin
                r_valid[i_mem.waddr] <= 1'b1;
            end
            r_rdv <= r_valid[i_mem.raddr];
        end
    end

    assign o_rdata = r_rdv ? r_rd : CELL_OPEN;

endmodule

[sv/gwf_ctrl.sv]
// Sequencer for the wall follower: robot state, start registers, grid reads and
// writes, and the result register. Uses gwf_pkg; drives the gwf_grid port.
module gwf_ctrl #(
    parameter int GRID_SIZE = gwf_pkg::GWF_GRID_SIZE
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_we,
    input  logic [1:0]               i_cfg_addr,
    input  logic [3:0]               i_cfg_wdata,
    input  logic                     i_in_valid,
    output logic                     o_in_ready,
    input  logic [1:0]               i_cmd,
    input  logic [3:0]               i_cell_x,
    input  logic [3:0]               i_cell_y,
    input  logic [1:0]               i_cell_kind,
    output gwf_pkg::t_mem_req        o_mem,
    input  logic [1:0]               i_rdata,
    output logic                     o_out_valid,
    input  logic                     i_out_ready,
    output logic [3:0]               o_pos_x,
    output logic [3:0]               o_pos_y,
    output logic [1:0]               o_dir,
    output logic                     o_on_marker,
    output logic                     o_trapped,
    output logic [15:0]              o_move_count
);
    import gwf_pkg::*;

    localparam int         LIM   = (GRID_SIZE < GWF_DIM) ? GRID_SIZE : GWF_DIM;
    localparam logic [4:0] LIM_W = 5'(LIM);

    typedef struct packed {
        logic [3:0] x;
        logic [3:0] y;
        logic       ok;
    } t_nb;

    // cell one step ahead of (x, y) along d; ok clear when off the grid
    function automatic t_nb nb_of(input logic [3:0] x, input logic [3:0] y,
                                  input logic [1:0] d);
        logic [4:0] nx;
        logic [4:0] ny;
        logic       ok;
        t_nb        r;
        nx = {1'b0, x};
        ny = {1'b0, y};
        ok = 1'b1;
        case (d)
            DIR_N: begin
                ok = (y != 4'd0);
                ny = ny - 5'd1;
            end
            DIR_E: begin
                nx = nx + 5'd1;
            end
            DIR_S: begin
                ny = ny + 5'd1;
            end
            default: begin
                ok = (x != 4'd0);
                nx = nx - 5'd1;
            end
        endcase
        r.x  = nx[3:0];
        r.y  = ny[3:0];
        r.ok = ok && (nx < LIM_W) && (ny < LIM_W);
        return r;
    endfunction

    t_state      r_state, n_state;
    logic [1:0]  r_cmd, n_cmd;
    logic [3:0]  r_x, n_x;
    logic [3:0]  r_y, n_y;
    logic [1:0]  r_dir, n_dir;
    logic [15:0] r_cnt, n_cnt;
    logic [1:0]  r_d, n_d;
    logic [1:0]  r_try, n_try;
    logic        r_mark, n_mark;
    logic        r_trap, n_trap;
    logic [3:0]  r_sx, r_sy;
    logic [1:0]  r_sdir;
    logic        n_out_load;

    t_nb  nb_cur;
    t_nb  nb_next;
    t_nb  nb_first;
    logic self_in;
    logic nb_wall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sx   <= RST_X;
            r_sy   <= RST_Y;
            r_sdir <= RST_DIR;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                REG_START_X:   r_sx   <= i_cfg_wdata;
                REG_START_Y:   r_sy   <= i_cfg_wdata;
                REG_START_DIR: r_sdir <= i_cfg_wdata[1:0];
                default: ;
            endcase
        end
    end

    assign o_in_ready = (r_state == ST_IDLE);
    assign self_in    = ({1'b0, r_x} < LIM_W) && ({1'b0, r_y} < LIM_W);
    assign nb_cur     = nb_of(r_x, r_y, r_d);
    assign nb_next    = nb_of(r_x, r_y, r_d + 2'd1);
    assign nb_first   = nb_of(r_x, r_y, r_dir + 2'd3);
    assign nb_wall    = !nb_cur.ok || (i_rdata == CELL_WALL);

    always_comb begin
        n_state    = r_state;
        n_cmd      = r_cmd;
        n_x        = r_x;
        n_y        = r_y;
        n_dir      = r_dir;
        n_cnt      = r_cnt;
        n_d        = r_d;
        n_try      = r_try;
        n_mark     = r_mark;
        n_trap     = r_trap;
        n_out_load = 1'b0;
        o_mem.we    = 1'b0;
        o_mem.waddr = {i_cell_y, i_cell_x};
        o_mem.wdata = (i_cell_kind == CELL_NONE) ? CELL_OPEN : i_cell_kind;
        o_mem.raddr = {r_y, r_x};

        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_cmd = i_cmd;
                    case (i_cmd)
                        CMD_LOAD: begin
                            o_mem.we = ({1'b0, i_cell_x} < LIM_W) &&
                                       ({1'b0, i_cell_y} < LIM_W);
                            n_state  = ST_SELF_RD;
                        end
                        CMD_RESTART: begin
                            n_x         = r_sx;
                            n_y         = r_sy;
                            n_dir       = r_sdir;
                            n_cnt       = '0;
                            o_mem.raddr = {r_sy, r_sx};
                            n_state     = ST_SELF_EVAL;
                        end
                        default: begin
                            n_state = ST_SELF_EVAL;
                        end
                    endcase
                end
            end
            ST_SELF_RD: begin
                n_state = ST_SELF_EVAL;
            end
            ST_SELF_EVAL: begin
                n_mark = self_in && (i_rdata == CELL_MARK);
                n_trap = 1'b0;
                if (r_cmd == CMD_STEP && !n_mark) begin
                    // look left first; read of the first candidate goes out now
                    n_d         = r_dir + 2'd3;
                    n_try       = 2'd0;
                    o_mem.raddr = {nb_first.y, nb_first.x};
                    n_state     = ST_NB;
                end else begin
                    n_state = ST_OUT;
                end
            end
            ST_NB: begin
                // data for r_d is here; next heading is read speculatively
                o_mem.raddr = {nb_next.y, nb_next.x};
                if (!nb_wall) begin
                    n_x     = nb_cur.x;
                    n_y     = nb_cur.y;
                    n_dir   = r_d;
                    n_cnt   = (r_cnt != 16'hFFFF) ? r_cnt + 16'd1 : r_cnt;
                    n_mark  = (i_rdata == CELL_MARK);
                    n_state = ST_OUT;
                end else if (r_try == 2'd3) begin
                    n_trap  = 1'b1;
                    n_mark  = 1'b0;
                    n_state = ST_OUT;
                end else begin
                    n_d   = r_d + 2'd1;
                    n_try = r_try + 2'd1;
                end
            end
            ST_OUT: begin
                if (!o_out_valid || i_out_ready) begin
                    n_out_load = 1'b1;
                    n_state    = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_x         <= RST_X;
            r_y         <= RST_Y;
            r_dir       <= RST_DIR;
            r_cnt       <= '0;
            o_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_x     <= n_x;
            r_y     <= n_y;
            r_dir   <= n_dir;
            r_cnt   <= n_cnt;
            if (n_out_load) begin
                o_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                o_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd  <= n_cmd;
        r_d    <= n_d;
        r_try  <= n_try;
        r_mark <= n_mark;
        r_trap <= n_trap;
        if (n_out_load) begin
            o_pos_x      <= r_x;
            o_pos_y      <= r_y;
            o_dir        <= r_dir;
            o_on_marker  <= r_mark;
            o_trapped    <= r_trap;
            o_move_count <= r_cnt;
        end
    end

endmodule

[sv/grid_wall_follower_step_core.sv]
// Accept to result valid: restart, an unknown command or a step on the marker pass
// ST_SELF_EVAL and ST_OUT; a load passes ST_SELF_RD first; a step checks k neighbors
// (k = 1..4) in ST_NB in between, one neighbor cell per cycle through the single grid
// memory read port. A new command is taken only back in ST_IDLE. Synchronous active-low reset
// clears control state and the cell valid bits at once, so all cells read open.
module grid_wall_follower_step_core #(
    parameter int GRID_SIZE = gwf_pkg::GWF_GRID_SIZE
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_addr,
    input  logic [3:0]  i_cfg_wdata,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [1:0]  i_cmd,
    input  logic [3:0]  i_cell_x,
    input  logic [3:0]  i_cell_y,
    input  logic [1:0]  i_cell_kind,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [3:0]  o_pos_x,
    output logic [3:0]  o_pos_y,
    output logic [1:0]  o_dir,
    output logic        o_on_marker,
    output logic        o_trapped,
    output logic [15:0] o_move_count
);
    import gwf_pkg::*;

    t_mem_req   w_mem;
    logic [1:0] w_rdata;

    gwf_grid u_grid (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_mem   (w_mem),
        .o_rdata (w_rdata)
    );

    gwf_ctrl #(
        .GRID_SIZE (GRID_SIZE)
    ) u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_addr   (i_cfg_addr),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_cmd        (i_cmd),
        .i_cell_x     (i_cell_x),
        .i_cell_y     (i_cell_y),
        .i_cell_kind  (i_cell_kind),
        .o_mem        (w_mem),
        .i_rdata      (w_rdata),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_pos_x      (o_pos_x),
        .o_pos_y      (o_pos_y),
        .o_dir        (o_dir),
        .o_on_marker  (o_on_marker),
        .o_trapped    (o_trapped),
        .o_move_count (o_move_count)
    );

endmodule
